/* rtl/fcst_pkg.sv */
// ----------------------------------------------------------------------------
// fcst_pkg
// Shared widths, command codes and the saturating add of the counting tree.
// ----------------------------------------------------------------------------
`default_nettype none

package fcst_pkg;

    // default number of leaf slots
    localparam int LEAVES_DEF = 1024;

    // transaction field widths
    localparam int LO_W    = 10;
    localparam int HI_W    = 11;
    localparam int COUNT_W = 32;

    // command codes
    localparam logic CMD_INC   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // saturating add at the top of the count range
    function automatic logic [COUNT_W-1:0] sat_add(
        input logic [COUNT_W-1:0] x,
        input logic [COUNT_W-1:0] y
    );
        logic [COUNT_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/fcst_node_ram.sv */
// ----------------------------------------------------------------------------
// fcst_node_ram
// Node count store in heap layout: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fcst_node_ram #(
    parameter int LEAVES = fcst_pkg::LEAVES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [$clog2(2*LEAVES)-1:0]       waddr,
    input  wire logic [fcst_pkg::COUNT_W-1:0]      wdata,
    input  wire logic [$clog2(2*LEAVES)-1:0]       raddr,
    output logic      [fcst_pkg::COUNT_W-1:0]      rdata
);

    localparam int DEPTH = 2 * LEAVES;

    logic [fcst_pkg::COUNT_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/frequency_count_segment_tree.sv */
// ----------------------------------------------------------------------------
// frequency_count_segment_tree
// Counting segment tree: point increment and saturating inclusive range sum,
// walked one node at a time through a shared saturating adder.
// ----------------------------------------------------------------------------
// channel | signals                         | direction | transaction
// in      | in_valid, in_ready, cmd, lo, hi | into      | one command
// out     | out_valid, out_ready, count     | out of    | one query total
//
// An increment updates one node per tree level, log2(2*LEAVES) levels, from the
// leaf up to the root. A query climbs level by level until its range edges meet,
// and an empty range goes straight to the output register.
// Each step is a read through the single read port of the node store, then the add.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, one per cycle,
// and in_ready stays low meanwhile.
// A query total waits in the output register; a new command is taken meanwhile,
// and only a second finished total stalls until the first one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_count_segment_tree #(
    parameter int LEAVES = fcst_pkg::LEAVES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                cmd,
    input  wire logic [fcst_pkg::LO_W-1:0]           lo,
    input  wire logic signed [fcst_pkg::HI_W-1:0]    hi,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [fcst_pkg::COUNT_W-1:0]        count
);

    localparam int NW = $clog2(2 * LEAVES);
    localparam int IW = NW + 1;
    localparam int CW = (IW > 12) ? IW : 12;
    localparam int CNT_W = fcst_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INC_RD,
        ST_INC_WR,
        ST_QRY_A,
        ST_QRY_B,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [NW-1:0]      clr_reg, clr_next;
    logic [NW-1:0]      k_reg, k_next;
    logic               first_reg, first_next;
    logic [IW-1:0]      a_reg, a_next;
    logic [IW-1:0]      b_reg, b_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // node store ports
    logic               we;
    logic [NW-1:0]      waddr;
    logic [CNT_W-1:0]   wdata;
    logic [NW-1:0]      raddr;
    logic [CNT_W-1:0]   rdata;

    // shared saturating adder
    logic [CNT_W-1:0]   sum;

    // command decode
    logic [CW-1:0]      lo_c;
    logic [CW-1:0]      hi_c;
    logic [CW-1:0]      last_c;
    logic               lo_ok;
    logic               empty;
    logic [IW-1:0]      b_dec;
    logic [NW-1:0]      parent;

    fcst_node_ram #(
        .LEAVES (LEAVES)
    ) u_node_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sum = fcst_pkg::sat_add(acc_reg, rdata);

    // range decode of an incoming command
    always_comb
    begin
        lo_c   = CW'(lo);
        hi_c   = CW'(hi[fcst_pkg::HI_W-2:0]);
        last_c = (hi_c >= CW'(LEAVES)) ? CW'(LEAVES - 1) : hi_c;
        lo_ok  = (lo_c < CW'(LEAVES));
        empty  = hi[fcst_pkg::HI_W-1] || !lo_ok || (last_c < lo_c);
    end

    assign b_dec  = b_reg[0] ? (b_reg - IW'(1)) : b_reg;
    assign parent = first_reg ? k_reg : (k_reg >> 1);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        k_next         = k_reg;
        first_next     = first_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        pend_next      = pend_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        we             = 1'b0;
        waddr          = k_reg;
        wdata          = sum;
        raddr          = k_reg;

        // output register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + NW'(1);
                if (clr_reg == NW'(2 * LEAVES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == fcst_pkg::CMD_INC)
                    begin
                        if (lo_ok)
                        begin
                            k_next     = NW'(lo_c + CW'(LEAVES));
                            first_next = 1'b1;
                            acc_next   = CNT_W'(1);
                            state_next = ST_INC_RD;
                        end
                    end
                    else if (empty)
                    begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        a_next     = IW'(lo_c + CW'(LEAVES));
                        b_next     = IW'(last_c + CW'(LEAVES) + CW'(1));
                        acc_next   = '0;
                        pend_next  = 1'b0;
                        state_next = ST_QRY_A;
                    end
                end
            end
            // read the leaf, or the sibling of the node just written
            ST_INC_RD:
            begin
                raddr      = first_reg ? k_reg : (k_reg ^ NW'(1));
                state_next = ST_INC_WR;
            end
            // write leaf plus one, or parent as sum of both children
            ST_INC_WR:
            begin
                we         = 1'b1;
                waddr      = parent;
                wdata      = sum;
                acc_next   = sum;
                k_next     = parent;
                first_next = 1'b0;
                state_next = (parent == NW'(1)) ? ST_IDLE : ST_INC_RD;
            end
            // left edge of the range walk
            ST_QRY_A:
            begin
                if (pend_reg)
                begin
                    acc_next = sum;
                end
                pend_next = 1'b0;
                if (a_reg >= b_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    if (a_reg[0])
                    begin
                        raddr     = a_reg[NW-1:0];
                        a_next    = a_reg + IW'(1);
                        pend_next = 1'b1;
                    end
                    state_next = ST_QRY_B;
                end
            end
            // right edge, then climb one level
            ST_QRY_B:
            begin
                if (pend_reg)
                begin
                    acc_next = sum;
                end
                pend_next = 1'b0;
                if (b_reg[0])
                begin
                    raddr     = b_dec[NW-1:0];
                    pend_next = 1'b1;
                end
                a_next     = a_reg >> 1;
                b_next     = b_dec >> 1;
                state_next = ST_QRY_A;
            end
            // hand the total to the output register once it is free
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            k_reg         <= '0;
            first_reg     <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            pend_reg      <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            k_reg         <= k_next;
            first_reg     <= first_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            pend_reg      <= pend_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign count     = count_reg;

    // no command taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
    else $error("command accepted while clearing");

    // tree update never wraps a count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INC_WR) |-> (sum >= rdata))
    else $error("node count wrapped");

    // range walk edges never cross
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QRY_A) |-> (a_reg <= b_reg))
    else $error("range walk edges crossed");

    // an increment never produces a total
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (cmd == fcst_pkg::CMD_INC) && !out_valid)
        |=> !out_valid)
    else $error("increment produced a result");

endmodule

`default_nettype wire
